// ----- rtl/gn2_pkg.sv -----
// shared constants and stage payload types for the gradient noise core
`timescale 1ns / 1ps
`default_nettype none

package gn2_pkg;

  // lattice geometry: the grid side is a power of two so cell wrap is a mask
  localparam int GRID_LOG2   = 4;
  localparam int GRID_SIZE   = 1 << GRID_LOG2;
  localparam int TABLE_DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_BITS   = 2 * GRID_LOG2;

  // fixed-point formats
  localparam int FRAC_BITS   = 8;
  localparam int COORD_BITS  = 12;
  localparam int ENTRY_BITS  = 8;
  localparam int GRAD_BITS   = 9;
  localparam int NOISE_BITS  = 10;

  // widths of the intermediate terms, sized for the largest reachable magnitude
  localparam int DOT_BITS    = FRAC_BITS + 11;
  localparam int ROW_BITS    = 2 * FRAC_BITS + 11;
  localparam int BLEND_BITS  = 3 * FRAC_BITS + 11;
  localparam int FLOOR_SHIFT = 3 * FRAC_BITS;
  localparam int QUOT_BITS   = BLEND_BITS - FLOOR_SHIFT;
  localparam int ENTRY_W     = 2 * GRAD_BITS;
  localparam int CORNERS     = 4;

  // request kinds carried on in_req_type
  localparam logic OP_EVAL   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [FRAC_BITS:0] FIX_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  localparam int NOISE_MAX = (1 << (NOISE_BITS - 1)) - 1;
  localparam int NOISE_MIN = -(1 << (NOISE_BITS - 1));

  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic signed [GRAD_BITS-1:0] grad_val_t;
  typedef logic signed [DOT_BITS-1:0]  dot_val_t;
  typedef logic signed [NOISE_BITS-1:0] noise_t;

  typedef struct packed {
    grad_val_t gx;
    grad_val_t gy;
  } grad_t;

  // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  typedef struct packed {
    frac_t                fx;
    frac_t                fy;
    logic [CORNERS-1:0]   gvld;
    grad_t [CORNERS-1:0]  g;
  } fetch_t;

  typedef struct packed {
    frac_t                  fx;
    frac_t                  fy;
    dot_val_t [CORNERS-1:0] n;
  } dot_t;

endpackage

`default_nettype wire

// ----- rtl/gn2_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module gn2_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/gn2_fetch.sv -----
// cell lookup and gradient table: four ram copies, one per corner, plus written flags
`timescale 1ns / 1ps
`default_nettype none

module gn2_fetch (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic                              in_req_type,
  input  wire logic [gn2_pkg::COORD_BITS-1:0]    in_coord_x,
  input  wire logic [gn2_pkg::COORD_BITS-1:0]    in_coord_y,
  input  wire logic [gn2_pkg::ENTRY_BITS-1:0]    in_entry_index,
  input  wire logic signed [gn2_pkg::GRAD_BITS-1:0] in_grad_x,
  input  wire logic signed [gn2_pkg::GRAD_BITS-1:0] in_grad_y,
  output gn2_pkg::fetch_t                        fetch
);
  import gn2_pkg::*;

  logic                         acc;
  logic                         wr_en;
  logic                         rd_en;
  logic [ADDR_BITS-1:0]         wr_addr;
  logic [ENTRY_W-1:0]           wr_data;
  logic [COORD_BITS+GRID_LOG2-1:0] ext_x;
  logic [COORD_BITS+GRID_LOG2-1:0] ext_y;
  logic [GRID_LOG2-1:0]         x0;
  logic [GRID_LOG2-1:0]         y0;
  logic [GRID_LOG2-1:0]         x1;
  logic [GRID_LOG2-1:0]         y1;
  logic [ADDR_BITS-1:0]         rd_addr [CORNERS];
  logic [ENTRY_W-1:0]           rd_data [CORNERS];
  logic [TABLE_DEPTH-1:0]       written_r;
  logic [TABLE_DEPTH-1:0]       written_nxt;
  logic [CORNERS-1:0]           gvld_r;
  frac_t                        fx_r;
  frac_t                        fy_r;

  assign acc   = in_valid && en;
  assign wr_en = acc && (in_req_type == OP_WRITE) && (32'(in_entry_index) < TABLE_DEPTH);
  assign rd_en = acc && (in_req_type == OP_EVAL);

  assign wr_addr = ADDR_BITS'(in_entry_index);
  assign wr_data = {in_grad_x, in_grad_y};

  // integer part wraps over the grid, fraction is the low bits
  assign ext_x = {GRID_LOG2'(0), in_coord_x} >> FRAC_BITS;
  assign ext_y = {GRID_LOG2'(0), in_coord_y} >> FRAC_BITS;
  assign x0    = ext_x[GRID_LOG2-1:0];
  assign y0    = ext_y[GRID_LOG2-1:0];
  assign x1    = x0 + GRID_LOG2'(1);
  assign y1    = y0 + GRID_LOG2'(1);

  assign rd_addr[0] = {y0, x0};
  assign rd_addr[1] = {y0, x1};
  assign rd_addr[2] = {y1, x0};
  assign rd_addr[3] = {y1, x1};

  for (genvar c = 0; c < CORNERS; c++) begin : g_copy
    gn2_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[c]),
      .rd_data (rd_data[c])
    );
  end

  always_comb begin
    written_nxt = written_r;
    if (wr_en) begin
      written_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  // flags and fraction are captured with the ram read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fx_r <= FRAC_BITS'(in_coord_x);
      fy_r <= FRAC_BITS'(in_coord_y);
      for (int c = 0; c < CORNERS; c++) begin
        gvld_r[c] <= written_r[rd_addr[c]];
      end
    end
  end

  always_comb begin
    fetch.fx   = fx_r;
    fetch.fy   = fy_r;
    fetch.gvld = gvld_r;
    for (int c = 0; c < CORNERS; c++) begin
      fetch.g[c] = rd_data[c];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gn2_dot.sv -----
// corner dot products of gradient and offset, one lane per corner
`timescale 1ns / 1ps
`default_nettype none

module gn2_dot (
  input  wire logic   clk,
  input  wire logic   en,
  input  gn2_pkg::fetch_t fetch,
  output gn2_pkg::dot_t   dot
);
  import gn2_pkg::*;

  dot_t dot_r;
  dot_t dot_nxt;

  always_comb begin
    logic signed [FRAC_BITS:0] dx;
    logic signed [FRAC_BITS:0] dy;
    grad_val_t                 gx;
    grad_val_t                 gy;
    dot_nxt.fx = fetch.fx;
    dot_nxt.fy = fetch.fy;
    for (int c = 0; c < CORNERS; c++) begin
      // far corner offset is frac minus one: same low bits, sign bit set
      dx = $signed({c[0], fetch.fx});
      dy = $signed({c[1], fetch.fy});
      // never-written entries read as zero
      gx = fetch.gvld[c] ? $signed(fetch.g[c].gx) : '0;
      gy = fetch.gvld[c] ? $signed(fetch.g[c].gy) : '0;
      dot_nxt.n[c] = DOT_BITS'(dx) * DOT_BITS'(gx) + DOT_BITS'(dy) * DOT_BITS'(gy);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= dot_nxt;
    end
  end

  assign dot = dot_r;

endmodule

`default_nettype wire

// ----- rtl/gn2_blend.sv -----
// row blend along x, column blend along y, then floor and saturate
`timescale 1ns / 1ps
`default_nettype none

module gn2_blend (
  input  wire logic       clk,
  input  wire logic       en,
  input  gn2_pkg::dot_t   dot,
  output gn2_pkg::noise_t noise
);
  import gn2_pkg::*;

  localparam logic signed [QUOT_BITS-1:0] Q_MAX = QUOT_BITS'(NOISE_MAX);
  localparam logic signed [QUOT_BITS-1:0] Q_MIN = QUOT_BITS'(NOISE_MIN);

  logic signed [FRAC_BITS+1:0]  wxa;
  logic signed [FRAC_BITS+1:0]  wxb;
  logic signed [FRAC_BITS+1:0]  wya;
  logic signed [FRAC_BITS+1:0]  wyb;
  logic signed [ROW_BITS-1:0]   row0_nxt;
  logic signed [ROW_BITS-1:0]   row1_nxt;
  logic signed [ROW_BITS-1:0]   row0_r;
  logic signed [ROW_BITS-1:0]   row1_r;
  frac_t                        fy_r;
  logic signed [BLEND_BITS-1:0] val_nxt;
  logic signed [BLEND_BITS-1:0] val_r;
  logic signed [QUOT_BITS-1:0]  quot;
  noise_t                       noise_nxt;
  noise_t                       noise_r;

  // weights one minus f and f, as signed terms
  assign wxa = $signed({1'b0, FIX_ONE - {1'b0, dot.fx}});
  assign wxb = $signed({2'b00, dot.fx});
  assign wya = $signed({1'b0, FIX_ONE - {1'b0, fy_r}});
  assign wyb = $signed({2'b00, fy_r});

  assign row0_nxt = ROW_BITS'($signed(dot.n[0])) * ROW_BITS'(wxa)
                  + ROW_BITS'($signed(dot.n[1])) * ROW_BITS'(wxb);
  assign row1_nxt = ROW_BITS'($signed(dot.n[2])) * ROW_BITS'(wxa)
                  + ROW_BITS'($signed(dot.n[3])) * ROW_BITS'(wxb);

  assign val_nxt = BLEND_BITS'(row0_r) * BLEND_BITS'(wya)
                 + BLEND_BITS'(row1_r) * BLEND_BITS'(wyb);

  // arithmetic shift is a floor toward minus infinity
  assign quot = QUOT_BITS'(val_r >>> FLOOR_SHIFT);

  always_comb begin
    if (quot > Q_MAX) begin
      noise_nxt = NOISE_BITS'(Q_MAX);
    end else if (quot < Q_MIN) begin
      noise_nxt = NOISE_BITS'(Q_MIN);
    end else begin
      noise_nxt = NOISE_BITS'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0_r  <= row0_nxt;
      row1_r  <= row1_nxt;
      fy_r    <= dot.fy;
      val_r   <= val_nxt;
      noise_r <= noise_nxt;
    end
  end

  assign noise = noise_r;

endmodule

`default_nettype wire

// ----- rtl/gradient_noise_2d_core.sv -----
// top level of the 2d gradient noise core: pipeline control and stage wiring
// a result reaches out_ through the read, dot, row, column and output registers
// throughput: one transaction per cycle, writes and evaluates alike
// the rate is set by the five-stage pipeline, which moves as one while out_ready holds
// reset (synchronous, active low) empties the pipeline and clears all written flags,
// so every gradient table entry reads as zero until it is written again
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_2d_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_req_type,
  input  wire logic [gn2_pkg::COORD_BITS-1:0]       in_coord_x,
  input  wire logic [gn2_pkg::COORD_BITS-1:0]       in_coord_y,
  input  wire logic [gn2_pkg::ENTRY_BITS-1:0]       in_entry_index,
  input  wire logic signed [gn2_pkg::GRAD_BITS-1:0] in_grad_x,
  input  wire logic signed [gn2_pkg::GRAD_BITS-1:0] in_grad_y,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [gn2_pkg::NOISE_BITS-1:0]     out_noise_value
);
  import gn2_pkg::*;

  // stage flags: table read, dot products, row blend, column blend, output
  logic   en;
  logic   eval_acc;
  logic   s1_vld_r;
  logic   s2_vld_r;
  logic   s3_vld_r;
  logic   s4_vld_r;
  logic   out_vld_r;
  fetch_t fetch;
  dot_t   dot;
  noise_t noise;

  // whole pipeline advances unless a finished result is held at the output
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;
  // write transactions update the table and leave a bubble behind
  assign eval_acc = in_valid && en && (in_req_type == OP_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= eval_acc;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  // stage 1: cell index, table read of all four corners
  gn2_fetch u_fetch (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_req_type    (in_req_type),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_entry_index (in_entry_index),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .fetch          (fetch)
  );

  // stage 2: corner dot products
  gn2_dot u_dot (
    .clk   (clk),
    .en    (en),
    .fetch (fetch),
    .dot   (dot)
  );

  // stages 3 to 5: x blend, y blend, floor and saturate into the output register
  gn2_blend u_blend (
    .clk   (clk),
    .en    (en),
    .dot   (dot),
    .noise (noise)
  );

  assign out_valid       = out_vld_r;
  assign out_noise_value = noise;

endmodule

`default_nettype wire

// ----- rtl/gn2_checker.sv -----
// port-level checks for the gradient noise core and their bind
`timescale 1ns / 1ps
`default_nettype none

module gn2_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [gn2_pkg::NOISE_BITS-1:0] out_noise_value
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transaction");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_noise_value))
    else $error("result changed while stalled");

  // input is taken whenever the output side is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind gradient_noise_2d_core gn2_checker u_gn2_checker (.*);

`default_nettype wire
